FILE: design/fdsc_pkg.sv
// ----------------------------------------------------------------------------
// FAT32 directory search package
// Shared command and status codes, attribute constants and the record that
// passes from the entry stage to the position stage.
// ----------------------------------------------------------------------------
`default_nettype none

package fdsc_pkg;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_ENTRY = 2'd1,
    CMD_FAT   = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_STARTED   = 3'd0,
    ST_SKIPPED   = 3'd1,
    ST_NONMATCH  = 3'd2,
    ST_MATCH     = 3'd3,
    ST_DIR_END   = 3'd4,
    ST_NEXT      = 3'd5,
    ST_CHAIN_END = 3'd6,
    ST_AFTER_END = 3'd7
  } status_e;

  localparam logic [2:0] CFG_NAME_BASE    = 3'd0;
  localparam logic [2:0] CFG_NAME_EXT     = 3'd1;
  localparam logic [2:0] CFG_DATA_START   = 3'd2;
  localparam logic [2:0] CFG_CLUSTER_SECS = 3'd3;
  localparam logic [2:0] CFG_FAT_BASE     = 3'd4;

  localparam logic [31:0] FAT_MASK     = 32'h0FFF_FFFF;
  localparam logic [31:0] FAT_EOC      = 32'h0FFF_FFF8;
  localparam logic [7:0]  NAME_END     = 8'h00;
  localparam logic [7:0]  NAME_DELETED = 8'hE5;
  localparam logic [7:0]  ATTR_LFN     = 8'h0F;
  localparam logic [7:0]  ATTR_VOL     = 8'h08;
  localparam logic [7:0]  ATTR_DIR     = 8'h10;

  typedef struct packed {
    status_e     status;
    logic [31:0] cluster;
    logic [31:0] size;
    logic        is_dir;
  } stage_t;

endpackage

`default_nettype wire

FILE: design/fat32_directory_search_chain_walk.sv
// ----------------------------------------------------------------------------
// FAT32 directory search and cluster chain walk
// Follows a lookup through a FAT32 directory: start items, directory entries
// and allocation table words go in, and one result word comes out per item.
//
// The input channel (in_valid_i/in_ready_o) takes start, entry and FAT words.
// The output channel (out_valid_o/out_ready_i) returns one word per input
// word, in order, with the status, current cluster, its data sector and the
// location of its table word. The entry stage decides and updates the lookup
// state when a word is accepted; the position stage then forms the sector
// numbers with one 32 by 8 bit multiply. A result word passes through the
// entry stage register and then the result register, and one word per cycle
// is sustained while the receiver takes each word.
// When the receiver stalls, the result register holds and the entry stage
// still takes one more word; further words wait until the output drains.
// Reset clears the current cluster and lookup flags and loads the register
// defaults, one sector per cluster and all else zero. The user must write
// registers through cfg_we_i only while no word is in flight; not enforced.
// ----------------------------------------------------------------------------
`default_nettype none

module fat32_directory_search_chain_walk #(
  parameter int unsigned SECTOR_BYTES = 512
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [63:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  cmd_i,
  input  wire logic [31:0] cluster_in_i,
  input  wire logic [63:0] entry_name_base_i,
  input  wire logic [23:0] entry_name_ext_i,
  input  wire logic [7:0]  entry_attr_i,
  input  wire logic [31:0] entry_size_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       status_o,
  output logic [31:0]      cluster_out_o,
  output logic [31:0]      cluster_lba_o,
  output logic [31:0]      table_sector_o,
  output logic [8:0]       table_offset_o,
  output logic [31:0]      size_out_o,
  output logic             is_dir_o
);

  logic [63:0] name_base_q;
  logic [23:0] name_ext_q;
  logic [31:0] data_start_q;
  logic [7:0]  clus_secs_q;
  logic [15:0] fat_base_q;

  logic s1_valid_q, out_valid_q;
  logic advance, load_s1;
  fdsc_pkg::stage_t s1_rec;

  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || advance;
  assign load_s1    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      name_base_q  <= 64'd0;
      name_ext_q   <= 24'd0;
      data_start_q <= 32'd0;
      clus_secs_q  <= 8'd1;
      fat_base_q   <= 16'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        fdsc_pkg::CFG_NAME_BASE:    name_base_q  <= cfg_wdata_i;
        fdsc_pkg::CFG_NAME_EXT:     name_ext_q   <= cfg_wdata_i[23:0];
        fdsc_pkg::CFG_DATA_START:   data_start_q <= cfg_wdata_i[31:0];
        fdsc_pkg::CFG_CLUSTER_SECS: clus_secs_q  <= cfg_wdata_i[7:0];
        fdsc_pkg::CFG_FAT_BASE:     fat_base_q   <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  fdsc_entry_stage u_entry (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .load_i             (load_s1),
    .cmd_i              (cmd_i),
    .cluster_in_i       (cluster_in_i),
    .entry_name_base_i  (entry_name_base_i),
    .entry_name_ext_i   (entry_name_ext_i),
    .entry_attr_i       (entry_attr_i),
    .entry_size_i       (entry_size_i),
    .target_name_base_i (name_base_q),
    .target_name_ext_i  (name_ext_q),
    .stage_o            (s1_rec)
  );

  fdsc_position_stage #(
    .SECTOR_BYTES (SECTOR_BYTES)
  ) u_position (
    .clk_i               (clk_i),
    .load_i              (advance && s1_valid_q),
    .stage_i             (s1_rec),
    .data_start_sector_i (data_start_q),
    .cluster_sectors_i   (clus_secs_q),
    .fat_base_sector_i   (fat_base_q),
    .status_o            (status_o),
    .cluster_out_o       (cluster_out_o),
    .cluster_lba_o       (cluster_lba_o),
    .table_sector_o      (table_sector_o),
    .table_offset_o      (table_offset_o),
    .size_out_o          (size_out_o),
    .is_dir_o            (is_dir_o)
  );

  assign out_valid_o = out_valid_q;

  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled while the output register is empty");

  a_size_only_on_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != fdsc_pkg::ST_MATCH)) |-> (size_out_o == 32'd0 && !is_dir_o))
    else $error("size or directory flag reported without a match");

  a_no_cluster_no_position: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (cluster_out_o == 32'd0)) |->
    (cluster_lba_o == 32'd0 && table_sector_o == 32'd0 && table_offset_o == 9'd0))
    else $error("position reported for cluster zero");

  a_chain_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == fdsc_pkg::ST_CHAIN_END)) |-> (cluster_out_o == 32'd0))
    else $error("chain end with a nonzero cluster");

endmodule

`default_nettype wire

FILE: design/fdsc_entry_stage.sv
// ----------------------------------------------------------------------------
// FAT32 directory search entry stage
// Classifies each accepted item, updates the lookup state and registers the
// status, current cluster, size and directory flag for the position stage.
// ----------------------------------------------------------------------------
`default_nettype none

module fdsc_entry_stage (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           load_i,
  input  wire logic [1:0]     cmd_i,
  input  wire logic [31:0]    cluster_in_i,
  input  wire logic [63:0]    entry_name_base_i,
  input  wire logic [23:0]    entry_name_ext_i,
  input  wire logic [7:0]     entry_attr_i,
  input  wire logic [31:0]    entry_size_i,
  input  wire logic [63:0]    target_name_base_i,
  input  wire logic [23:0]    target_name_ext_i,
  output fdsc_pkg::stage_t    stage_o
);

  logic [31:0]      cur_q, cur_d;
  logic             match_q, match_d;
  logic             ended_q, ended_d;
  fdsc_pkg::stage_t rec_d;
  fdsc_pkg::stage_t rec_q;
  logic [7:0]       first_byte;
  logic [31:0]      fat_val;

  assign first_byte = entry_name_base_i[7:0];
  assign fat_val    = cluster_in_i & fdsc_pkg::FAT_MASK;

  always_comb begin
    cur_d         = cur_q;
    match_d       = match_q;
    ended_d       = ended_q;
    rec_d.status  = fdsc_pkg::ST_AFTER_END;
    rec_d.size    = 32'd0;
    rec_d.is_dir  = 1'b0;
    case (cmd_i)
      fdsc_pkg::CMD_START: begin
        cur_d        = cluster_in_i;
        match_d      = 1'b0;
        ended_d      = 1'b0;
        rec_d.status = fdsc_pkg::ST_STARTED;
      end
      fdsc_pkg::CMD_ENTRY: begin
        if (ended_q) begin
          rec_d.status = fdsc_pkg::ST_AFTER_END;
        end else if (first_byte == fdsc_pkg::NAME_END) begin
          ended_d      = 1'b1;
          rec_d.status = fdsc_pkg::ST_DIR_END;
        end else if ((first_byte == fdsc_pkg::NAME_DELETED) ||
                     (entry_attr_i == fdsc_pkg::ATTR_LFN) ||
                     ((entry_attr_i & fdsc_pkg::ATTR_VOL) != 8'd0)) begin
          rec_d.status = fdsc_pkg::ST_SKIPPED;
        end else if (!match_q && (entry_name_base_i == target_name_base_i) &&
                     (entry_name_ext_i == target_name_ext_i)) begin
          match_d      = 1'b1;
          cur_d        = cluster_in_i;
          rec_d.status = fdsc_pkg::ST_MATCH;
          rec_d.size   = entry_size_i;
          rec_d.is_dir = (entry_attr_i & fdsc_pkg::ATTR_DIR) != 8'd0;
        end else begin
          rec_d.status = fdsc_pkg::ST_NONMATCH;
        end
      end
      fdsc_pkg::CMD_FAT: begin
        if (cur_q == 32'd0) begin
          rec_d.status = fdsc_pkg::ST_AFTER_END;
        end else if (fat_val >= fdsc_pkg::FAT_EOC) begin
          cur_d        = 32'd0;
          rec_d.status = fdsc_pkg::ST_CHAIN_END;
        end else begin
          cur_d        = fat_val;
          rec_d.status = fdsc_pkg::ST_NEXT;
        end
      end
      default: begin
        rec_d.status = fdsc_pkg::ST_AFTER_END;
      end
    endcase
    rec_d.cluster = cur_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q   <= 32'd0;
      match_q <= 1'b0;
      ended_q <= 1'b0;
    end else if (load_i) begin
      cur_q   <= cur_d;
      match_q <= match_d;
      ended_q <= ended_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rec_q <= rec_d;
    end
  end

  assign stage_o = rec_q;

endmodule

`default_nettype wire

FILE: design/fdsc_position_stage.sv
// ----------------------------------------------------------------------------
// FAT32 directory search position stage
// Turns the current cluster into its data sector and the sector and byte
// offset of its allocation table word, and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fdsc_position_stage #(
  parameter int unsigned SECTOR_BYTES = 512
) (
  input  wire logic           clk_i,
  input  wire logic           load_i,
  input  fdsc_pkg::stage_t    stage_i,
  input  wire logic [31:0]    data_start_sector_i,
  input  wire logic [7:0]     cluster_sectors_i,
  input  wire logic [15:0]    fat_base_sector_i,
  output logic [2:0]          status_o,
  output logic [31:0]         cluster_out_o,
  output logic [31:0]         cluster_lba_o,
  output logic [31:0]         table_sector_o,
  output logic [8:0]          table_offset_o,
  output logic [31:0]         size_out_o,
  output logic                is_dir_o
);

  localparam int unsigned SectShift = $clog2(SECTOR_BYTES);

  logic [31:0] clus;
  logic [31:0] clus_m2;
  logic [31:0] prod;
  logic [31:0] byte_off;
  logic        none;
  logic [31:0] lba_d, sec_d;
  logic [8:0]  off_d;

  logic [2:0]  status_q;
  logic [31:0] cluster_q, lba_q, sec_q, size_q;
  logic [8:0]  off_q;
  logic        is_dir_q;

  assign clus     = stage_i.cluster;
  assign none     = (clus == 32'd0);
  assign clus_m2  = clus - 32'd2;
  assign prod     = clus_m2 * {24'd0, cluster_sectors_i};
  assign byte_off = {clus[29:0], 2'b00};

  always_comb begin
    lba_d = data_start_sector_i + prod;
    sec_d = {16'd0, fat_base_sector_i} + (byte_off >> SectShift);
    off_d = byte_off[8:0];
    if (none) begin
      lba_d = 32'd0;
      sec_d = 32'd0;
      off_d = 9'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      status_q  <= stage_i.status;
      cluster_q <= clus;
      lba_q     <= lba_d;
      sec_q     <= sec_d;
      off_q     <= off_d;
      size_q    <= stage_i.size;
      is_dir_q  <= stage_i.is_dir;
    end
  end

  assign status_o       = status_q;
  assign cluster_out_o  = cluster_q;
  assign cluster_lba_o  = lba_q;
  assign table_sector_o = sec_q;
  assign table_offset_o = off_q;
  assign size_out_o     = size_q;
  assign is_dir_o       = is_dir_q;

endmodule

`default_nettype wire
